// File: hdl/qph_pkg.sv
// Package for the quadratic probe hash set: sizes, codes and payload types.
// Used by every module of the block but qph_ram; depends on nothing.
package qph_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_W       = 11;
  localparam int KEY_W       = 31;
  localparam int ENTRY_W     = KEY_W + 1;
  localparam int SLOT_OUT_W  = 10;
  localparam int COLL_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STEPS   = (KEY_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W       = DIV_STEPS * DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [COLL_W-1:0]     collision_count;
  } result_t;

  typedef struct packed {
    logic                load_item;
    logic                div_step;
    logic                probe_init;
    logic                probe_adv;
    logic                key_wr;
    logic                clear_wr;
    logic                status_load;
    logic [STATUS_W-1:0] status_code;
    logic                res_load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic entry_empty;
    logic key_match;
    logic probe_last;
    logic is_insert;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/qph_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module qph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/qph_ctrl.sv
// Controller state machine of the quadratic probe hash set.
// Depends on qph_pkg; drives the datapath through cmd_t and reads sts_t.
module qph_ctrl
  import qph_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_INIT  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.probe_init = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.entry_empty) begin
          cmd.status_load = 1'b1;
          if (sts.is_insert) begin
            cmd.key_wr = 1'b1;
            cmd.status_code = ST_OK;
          end else begin
            cmd.status_code = ST_MISS;
          end
          state_next = S_DONE;
        end else if (sts.key_match) begin
          cmd.status_load = 1'b1;
          cmd.status_code = ST_OK;
          state_next = S_DONE;
        end else if (sts.probe_last) begin
          cmd.status_load = 1'b1;
          cmd.status_code = ST_FULL;
          state_next = S_DONE;
        end else begin
          cmd.probe_adv = 1'b1;
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_key_wr_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.key_wr |-> sts.entry_empty && sts.is_insert)
    else $error("key written to an occupied slot");
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> sts.out_free)
    else $error("result loaded over an unaccepted result");
  a_adv_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.probe_adv |-> !sts.probe_last && !sts.entry_empty && !sts.key_match)
    else $error("probe advanced past a terminal slot");
  a_load_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> cmd.div_step && !req_ready)
    else $error("accepted request did not start the home slot division");
`endif

endmodule

// File: hdl/qph_datapath.sv
// Datapath of the quadratic probe hash set: divider, probe walk, slot store,
// collision total and result register. Depends on qph_pkg and qph_ram.
module qph_datapath
  import qph_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  req_t              req,
  input  logic [SIZE_W-1:0] eff_size,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result
);

  logic                 op;
  logic [KEY_W-1:0]     key;
  logic [SIZE_W-1:0]    size;
  logic [DIV_W-1:0]     dividend;
  logic [SIZE_W-1:0]    rem;
  logic [SIZE_W-1:0]    rem_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SIZE_W-1:0]    idx;
  logic [SIZE_W-1:0]    idx_next;
  logic [SIZE_W-1:0]    delta;
  logic [SIZE_W-1:0]    delta_next;
  logic [SIZE_W-1:0]    step;
  logic [COLL_W-1:0]    coll;
  logic [STATUS_W-1:0]  stat;
  logic [SLOT_W-1:0]    clr_cnt;
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;

  always_comb begin
    logic [SIZE_W:0]   t;
    logic [SIZE_W-1:0] r;
    r = rem;
    for (int b = 0; b < DIV_BITS; b++) begin
      t = {r, dividend[DIV_W-1-b]};
      if (t >= {1'b0, size}) begin
        t = t - {1'b0, size};
      end
      r = t[SIZE_W-1:0];
    end
    rem_next = r;
  end

  always_comb begin
    logic [SIZE_W:0] s;
    logic [SIZE_W:0] d;
    s = {1'b0, idx} + {1'b0, delta};
    if (s >= {1'b0, size}) begin
      s = s - {1'b0, size};
    end
    idx_next = s[SIZE_W-1:0];
    d = {1'b0, delta} + (SIZE_W + 1)'(2);
    if (d >= {1'b0, size}) begin
      d = d - {1'b0, size};
    end
    if (d >= {1'b0, size}) begin
      d = d - {1'b0, size};
    end
    delta_next = d[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op <= req.opcode;
      key <= req.key;
      size <= eff_size;
      dividend <= DIV_W'(req.key);
      rem <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      dividend <= dividend << DIV_BITS;
      rem <= rem_next;
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.probe_init) begin
      idx <= rem;
      delta <= (size == SIZE_W'(1)) ? '0 : SIZE_W'(1);
      step <= '0;
    end
    if (cmd.probe_adv) begin
      idx <= idx_next;
      delta <= delta_next;
      step <= step + SIZE_W'(1);
    end
    if (cmd.status_load) begin
      stat <= cmd.status_code;
    end
    if (cmd.res_load) begin
      result.status <= stat;
      result.slot <= SLOT_OUT_W'(idx);
      result.collision_count <= coll;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coll <= '0;
      result_valid <= 1'b0;
      clr_cnt <= '0;
    end else begin
      if (cmd.probe_adv && op == OP_INSERT) begin
        coll <= coll + COLL_W'(1);
      end
      if (cmd.res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cmd.clear_wr) begin
        clr_cnt <= clr_cnt + SLOT_W'(1);
      end
    end
  end

  always_comb begin
    ram_we = cmd.clear_wr || cmd.key_wr;
    if (cmd.clear_wr) begin
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_waddr = SLOT_W'(idx);
      ram_wdata = {1'b1, key};
    end
  end

  qph_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(SLOT_W'(idx)),
    .rdata(ram_rdata)
  );

  always_comb begin
    sts.clear_done  = (clr_cnt == SLOT_W'(TABLE_DEPTH - 1));
    sts.div_done    = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    sts.entry_empty = !ram_rdata[KEY_W];
    sts.key_match   = (ram_rdata[KEY_W-1:0] == key);
    sts.probe_last  = (step == size - SIZE_W'(1));
    sts.is_insert   = (op == OP_INSERT);
    sts.out_free    = !result_valid || result_ready;
  end

endmodule

// File: hdl/quadratic_probe_hash_set_unit.sv
// Top level of the quadratic probe hash set: APB register and the
// controller and datapath. Depends on qph_pkg, qph_ctrl and qph_datapath.
//
//   Channel   Signals                                  Direction
//   request   req_valid, req_ready, req (req_t)        in
//   result    result_valid, result_ready, result       out
//   config    psel, penable, pwrite, paddr, pwdata,    in / out
//             prdata, pready
//
// After reset the slot store is cleared slot by slot, and no request is
// taken until that pass ends; configuration writes are taken at any time.
// A request is handled in steps: the 4-bit-per-cycle remainder unit finds the
// home slot, then each probed slot takes one RAM read and one compare on the
// single read port.
// The next request can be taken in the cycle after the result is loaded.
// A waiting result stalls only the loading of the next result.
module quadratic_probe_hash_set_unit
  import qph_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CFG_W-1:0]  table_size;
  logic [SIZE_W-1:0] eff_size;
  cmd_t              cmd;
  sts_t              sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= CFG_W'(TABLE_DEPTH);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TABLE_SIZE) begin
      table_size <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TABLE_SIZE) begin
      prdata = APB_DATA_W'(table_size);
    end
  end

  always_comb begin
    if (table_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if ((CFG_W + SIZE_W)'(table_size) > (CFG_W + SIZE_W)'(TABLE_DEPTH)) begin
      eff_size = SIZE_W'(TABLE_DEPTH);
    end else begin
      eff_size = SIZE_W'(table_size);
    end
  end

  qph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qph_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .eff_size    (eff_size),
    .cmd         (cmd),
    .sts         (sts),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule
